// ----- rtl/core/bptc_pkg.sv -----
// Shared types, constants and micro-program for the barometric compensation block.
// No dependencies; every other file of the block imports this package.
package bptc_pkg;

  localparam int DATA_W    = 32;
  localparam int RAW_W     = 20;
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 6;
  localparam int SH_W      = 5;

  // constants of the compensation formula
  localparam logic [DATA_W-1:0] K_FINE_OFS  = 32'd64000;
  localparam logic [DATA_W-1:0] K_P4_SCALE  = 32'd65536;
  localparam logic [DATA_W-1:0] K_P1_OFS    = 32'd32768;
  localparam logic [DATA_W-1:0] K_RAW_FULL  = 32'd1048576;
  localparam logic [DATA_W-1:0] K_PRES_MUL  = 32'd3125;
  localparam logic [DATA_W-1:0] K_TEMP_MUL  = 32'd5;
  localparam logic [DATA_W-1:0] K_TEMP_RND  = 32'd128;
  localparam logic [DATA_W-1:0] K_TWO       = 32'd2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_CAL_ONE,
    CFG_TEMP_CAL_TWO,
    CFG_TEMP_CAL_THREE,
    CFG_PRES_CAL_ONE_TWO,
    CFG_PRES_CAL_THREE_FOUR,
    CFG_PRES_CAL_FIVE_SIX,
    CFG_PRES_CAL_SEVEN_EIGHT,
    CFG_PRES_CAL_NINE
  } cfg_idx_t;

  // unpacked calibration coefficients
  typedef struct packed {
    logic [COEF_W-1:0] t1;
    logic [COEF_W-1:0] t2;
    logic [COEF_W-1:0] t3;
    logic [COEF_W-1:0] p1;
    logic [COEF_W-1:0] p2;
    logic [COEF_W-1:0] p3;
    logic [COEF_W-1:0] p4;
    logic [COEF_W-1:0] p5;
    logic [COEF_W-1:0] p6;
    logic [COEF_W-1:0] p7;
    logic [COEF_W-1:0] p8;
    logic [COEF_W-1:0] p9;
  } cal_t;

  // shared unit operations
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_SRA,   // signed divide by 2^b, truncating toward zero
    OP_SRL,   // unsigned divide by 2^b
    OP_BZ,    // finish with operand b when operand a is zero
    OP_DIV    // serial unsigned divide of the pressure term
  } op_t;

  typedef enum logic [4:0] {
    SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4,
    SRC_RAW, SRC_FINE,
    SRC_T1, SRC_T2, SRC_T3,
    SRC_P1, SRC_P2, SRC_P3, SRC_P4, SRC_P5, SRC_P6, SRC_P7, SRC_P8, SRC_P9,
    SRC_IMM
  } src_t;

  typedef enum logic [2:0] {
    DST_R0, DST_R1, DST_R2, DST_R3, DST_R4, DST_FINE
  } dst_t;

  typedef struct packed {
    op_t               op;
    dst_t              dst;
    src_t              a;
    src_t              b;
    logic [DATA_W-1:0] imm;
    logic              last;
  } uop_t;

  function automatic uop_t mk(input op_t op, input dst_t dst, input src_t a,
                              input src_t b, input logic [DATA_W-1:0] imm,
                              input logic last);
    uop_t u;
    u.op   = op;
    u.dst  = dst;
    u.a    = a;
    u.b    = b;
    u.imm  = imm;
    u.last = last;
    return u;
  endfunction

  // temperature program: fine temperature, then centi-degrees
  function automatic uop_t temp_uop(input logic [STEP_W-1:0] step);
    uop_t u;
    case (step)
      6'd0:    u = mk(OP_SRA, DST_R0,   SRC_RAW,  SRC_IMM, 32'd3,  1'b0);
      6'd1:    u = mk(OP_ADD, DST_R1,   SRC_T1,   SRC_T1,  32'd0,  1'b0);
      6'd2:    u = mk(OP_SUB, DST_R0,   SRC_R0,   SRC_R1,  32'd0,  1'b0);
      6'd3:    u = mk(OP_MUL, DST_R0,   SRC_R0,   SRC_T2,  32'd0,  1'b0);
      6'd4:    u = mk(OP_SRA, DST_R0,   SRC_R0,   SRC_IMM, 32'd11, 1'b0);
      6'd5:    u = mk(OP_SRA, DST_R1,   SRC_RAW,  SRC_IMM, 32'd4,  1'b0);
      6'd6:    u = mk(OP_SUB, DST_R1,   SRC_R1,   SRC_T1,  32'd0,  1'b0);
      6'd7:    u = mk(OP_MUL, DST_R1,   SRC_R1,   SRC_R1,  32'd0,  1'b0);
      6'd8:    u = mk(OP_SRA, DST_R1,   SRC_R1,   SRC_IMM, 32'd12, 1'b0);
      6'd9:    u = mk(OP_MUL, DST_R1,   SRC_R1,   SRC_T3,  32'd0,  1'b0);
      6'd10:   u = mk(OP_SRA, DST_R1,   SRC_R1,   SRC_IMM, 32'd14, 1'b0);
      6'd11:   u = mk(OP_ADD, DST_FINE, SRC_R0,   SRC_R1,  32'd0,  1'b0);
      6'd12:   u = mk(OP_MUL, DST_R0,   SRC_FINE, SRC_IMM, K_TEMP_MUL, 1'b0);
      6'd13:   u = mk(OP_ADD, DST_R0,   SRC_R0,   SRC_IMM, K_TEMP_RND, 1'b0);
      6'd14:   u = mk(OP_SRA, DST_R0,   SRC_R0,   SRC_IMM, 32'd8,  1'b1);
      default: u = mk(OP_ADD, DST_R0,   SRC_R0,   SRC_R0,  32'd0,  1'b1);
    endcase
    return u;
  endfunction

  // pressure program: divisor in r3, pressure term in r0
  function automatic uop_t pres_uop(input logic [STEP_W-1:0] step);
    uop_t u;
    case (step)
      6'd0:    u = mk(OP_SRA, DST_R0, SRC_FINE, SRC_IMM, 32'd1,  1'b0);
      6'd1:    u = mk(OP_SUB, DST_R0, SRC_R0,   SRC_IMM, K_FINE_OFS, 1'b0);
      6'd2:    u = mk(OP_SRA, DST_R1, SRC_R0,   SRC_IMM, 32'd2,  1'b0);
      6'd3:    u = mk(OP_MUL, DST_R1, SRC_R1,   SRC_R1,  32'd0,  1'b0);
      6'd4:    u = mk(OP_SRA, DST_R2, SRC_R1,   SRC_IMM, 32'd11, 1'b0);
      6'd5:    u = mk(OP_MUL, DST_R2, SRC_R2,   SRC_P6,  32'd0,  1'b0);
      6'd6:    u = mk(OP_MUL, DST_R3, SRC_R0,   SRC_P5,  32'd0,  1'b0);
      6'd7:    u = mk(OP_MUL, DST_R3, SRC_R3,   SRC_IMM, K_TWO,  1'b0);
      6'd8:    u = mk(OP_ADD, DST_R2, SRC_R2,   SRC_R3,  32'd0,  1'b0);
      6'd9:    u = mk(OP_SRA, DST_R2, SRC_R2,   SRC_IMM, 32'd2,  1'b0);
      6'd10:   u = mk(OP_MUL, DST_R3, SRC_P4,   SRC_IMM, K_P4_SCALE, 1'b0);
      6'd11:   u = mk(OP_ADD, DST_R2, SRC_R2,   SRC_R3,  32'd0,  1'b0);
      6'd12:   u = mk(OP_SRA, DST_R3, SRC_R1,   SRC_IMM, 32'd13, 1'b0);
      6'd13:   u = mk(OP_MUL, DST_R3, SRC_P3,   SRC_R3,  32'd0,  1'b0);
      6'd14:   u = mk(OP_SRA, DST_R3, SRC_R3,   SRC_IMM, 32'd3,  1'b0);
      6'd15:   u = mk(OP_MUL, DST_R4, SRC_P2,   SRC_R0,  32'd0,  1'b0);
      6'd16:   u = mk(OP_SRA, DST_R4, SRC_R4,   SRC_IMM, 32'd1,  1'b0);
      6'd17:   u = mk(OP_ADD, DST_R3, SRC_R3,   SRC_R4,  32'd0,  1'b0);
      6'd18:   u = mk(OP_SRA, DST_R3, SRC_R3,   SRC_IMM, 32'd18, 1'b0);
      6'd19:   u = mk(OP_ADD, DST_R3, SRC_R3,   SRC_IMM, K_P1_OFS, 1'b0);
      6'd20:   u = mk(OP_MUL, DST_R3, SRC_R3,   SRC_P1,  32'd0,  1'b0);
      6'd21:   u = mk(OP_SRA, DST_R3, SRC_R3,   SRC_IMM, 32'd15, 1'b0);
      6'd22:   u = mk(OP_SUB, DST_R0, SRC_IMM,  SRC_RAW, K_RAW_FULL, 1'b0);
      6'd23:   u = mk(OP_SRA, DST_R1, SRC_R2,   SRC_IMM, 32'd12, 1'b0);
      6'd24:   u = mk(OP_SUB, DST_R0, SRC_R0,   SRC_R1,  32'd0,  1'b0);
      6'd25:   u = mk(OP_MUL, DST_R0, SRC_R0,   SRC_IMM, K_PRES_MUL, 1'b0);
      6'd26:   u = mk(OP_BZ,  DST_R0, SRC_R3,   SRC_R0,  32'd0,  1'b0);
      6'd27:   u = mk(OP_DIV, DST_R0, SRC_R0,   SRC_R3,  32'd0,  1'b0);
      6'd28:   u = mk(OP_SRL, DST_R1, SRC_R0,   SRC_IMM, 32'd3,  1'b0);
      6'd29:   u = mk(OP_MUL, DST_R1, SRC_R1,   SRC_R1,  32'd0,  1'b0);
      6'd30:   u = mk(OP_SRL, DST_R1, SRC_R1,   SRC_IMM, 32'd13, 1'b0);
      6'd31:   u = mk(OP_MUL, DST_R1, SRC_P9,   SRC_R1,  32'd0,  1'b0);
      6'd32:   u = mk(OP_SRA, DST_R1, SRC_R1,   SRC_IMM, 32'd12, 1'b0);
      6'd33:   u = mk(OP_SRL, DST_R2, SRC_R0,   SRC_IMM, 32'd2,  1'b0);
      6'd34:   u = mk(OP_MUL, DST_R2, SRC_R2,   SRC_P8,  32'd0,  1'b0);
      6'd35:   u = mk(OP_SRA, DST_R2, SRC_R2,   SRC_IMM, 32'd13, 1'b0);
      6'd36:   u = mk(OP_ADD, DST_R1, SRC_R1,   SRC_R2,  32'd0,  1'b0);
      6'd37:   u = mk(OP_ADD, DST_R1, SRC_R1,   SRC_P7,  32'd0,  1'b0);
      6'd38:   u = mk(OP_SRA, DST_R1, SRC_R1,   SRC_IMM, 32'd4,  1'b0);
      6'd39:   u = mk(OP_ADD, DST_R0, SRC_R0,   SRC_R1,  32'd0,  1'b1);
      default: u = mk(OP_ADD, DST_R0, SRC_R0,   SRC_R0,  32'd0,  1'b1);
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/core/bptc_in_if.sv -----
// Input channel of the compensation block: valid/ready plus the raw sample beat.
// Depends on bptc_pkg for field widths.
interface bptc_in_if;
  import bptc_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [RAW_W-1:0] raw_sample;

  modport source (output valid, mode, raw_sample, input ready);
  modport sink   (input valid, mode, raw_sample, output ready);
endinterface

// ----- rtl/core/bptc_out_if.sv -----
// Result channel of the compensation block: valid/ready plus the result beat.
// Depends on bptc_pkg for field widths.
interface bptc_out_if;
  import bptc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic signed [DATA_W-1:0] temperature_centi;
  logic [DATA_W-1:0]        pressure_pa;

  modport source (output valid, result_kind, temperature_centi, pressure_pa, input ready);
  modport sink   (input valid, result_kind, temperature_centi, pressure_pa, output ready);
endinterface

// ----- rtl/core/bptc_alu.sv -----
// Shared arithmetic unit: add, subtract, wrapping multiply and power-of-two divides.
// Depends on bptc_pkg for the operation codes.
module bptc_alu (
  input  bptc_pkg::op_t               op,
  input  logic [bptc_pkg::DATA_W-1:0] a,
  input  logic [bptc_pkg::DATA_W-1:0] b,
  output logic [bptc_pkg::DATA_W-1:0] y
);
  import bptc_pkg::*;

  logic [SH_W-1:0]   sh;
  logic [DATA_W-1:0] bias;
  logic [DATA_W-1:0] biased;
  logic [DATA_W-1:0] prod;

  // low word of the product is the same for signed and unsigned operands
  assign prod = a * b;

  // negative values get 2^sh-1 added so the arithmetic shift truncates toward zero
  assign sh     = b[SH_W-1:0];
  assign bias   = a[DATA_W-1] ? ((DATA_W'(1) << sh) - DATA_W'(1)) : '0;
  assign biased = a + bias;

  always_comb begin
    case (op)
      OP_ADD:  y = a + b;
      OP_SUB:  y = a - b;
      OP_MUL:  y = prod;
      OP_SRA:  y = DATA_W'($signed(biased) >>> sh);
      OP_SRL:  y = a >> sh;
      default: y = a;
    endcase
  end
endmodule

// ----- rtl/core/bptc_div.sv -----
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on bptc_pkg for the data width.
module bptc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bptc_pkg::DATA_W-1:0] dividend,
  input  logic [bptc_pkg::DATA_W-1:0] divisor,
  output logic                        done,
  output logic [bptc_pkg::DATA_W-1:0] quotient
);
  import bptc_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  typedef enum logic {ST_IDLE, ST_BUSY} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  // trial subtract of the shifted partial remainder
  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          quo_nxt   = dividend;
          rem_nxt   = '0;
          dvs_nxt   = divisor;
          cnt_nxt   = CNT_W'(DATA_W - 1);
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (!diff[DATA_W]) begin
          rem_nxt = diff[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

// ----- rtl/core/bptc_seq.sv -----
// Micro-program sequencer: working registers, fine temperature and the shared units.
// Depends on bptc_pkg, bptc_alu and bptc_div.
module bptc_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        mode,
  input  logic [bptc_pkg::RAW_W-1:0]  raw,
  input  bptc_pkg::cal_t              cal,
  input  logic                        res_ready,
  output logic                        busy,
  output logic                        res_valid,
  output logic                        res_kind,
  output logic [bptc_pkg::DATA_W-1:0] res_value
);
  import bptc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV} state_t;

  typedef struct packed {
    logic [DATA_W-1:0] r0;
    logic [DATA_W-1:0] r1;
    logic [DATA_W-1:0] r2;
    logic [DATA_W-1:0] r3;
    logic [DATA_W-1:0] r4;
    logic [DATA_W-1:0] raw;
    logic [DATA_W-1:0] fine;
    logic [DATA_W-1:0] imm;
  } opnd_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              mode_r, mode_nxt;
  logic [RAW_W-1:0]  raw_r, raw_nxt;
  logic [DATA_W-1:0] r0_r, r0_nxt;
  logic [DATA_W-1:0] r1_r, r1_nxt;
  logic [DATA_W-1:0] r2_r, r2_nxt;
  logic [DATA_W-1:0] r3_r, r3_nxt;
  logic [DATA_W-1:0] r4_r, r4_nxt;
  logic [DATA_W-1:0] fine_r, fine_nxt;
  logic              dflag_r, dflag_nxt;

  uop_t              uop;
  opnd_t             opnd;
  logic [DATA_W-1:0] a_val;
  logic [DATA_W-1:0] b_val;
  logic [DATA_W-1:0] alu_y;
  logic              finish;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_dividend;
  logic [DATA_W-1:0] div_quo;

  function automatic logic [DATA_W-1:0] sx(input logic [COEF_W-1:0] v);
    return {{(DATA_W-COEF_W){v[COEF_W-1]}}, v};
  endfunction

  function automatic logic [DATA_W-1:0] pick(input src_t s, input opnd_t o,
                                             input cal_t c);
    logic [DATA_W-1:0] v;
    case (s)
      SRC_R0:   v = o.r0;
      SRC_R1:   v = o.r1;
      SRC_R2:   v = o.r2;
      SRC_R3:   v = o.r3;
      SRC_R4:   v = o.r4;
      SRC_RAW:  v = o.raw;
      SRC_FINE: v = o.fine;
      SRC_T1:   v = {{(DATA_W-COEF_W){1'b0}}, c.t1};
      SRC_T2:   v = sx(c.t2);
      SRC_T3:   v = sx(c.t3);
      SRC_P1:   v = {{(DATA_W-COEF_W){1'b0}}, c.p1};
      SRC_P2:   v = sx(c.p2);
      SRC_P3:   v = sx(c.p3);
      SRC_P4:   v = sx(c.p4);
      SRC_P5:   v = sx(c.p5);
      SRC_P6:   v = sx(c.p6);
      SRC_P7:   v = sx(c.p7);
      SRC_P8:   v = sx(c.p8);
      SRC_P9:   v = sx(c.p9);
      default:  v = o.imm;
    endcase
    return v;
  endfunction

  // current micro-op and its operands
  always_comb begin
    uop       = mode_r ? pres_uop(step_r) : temp_uop(step_r);
    opnd.r0   = r0_r;
    opnd.r1   = r1_r;
    opnd.r2   = r2_r;
    opnd.r3   = r3_r;
    opnd.r4   = r4_r;
    opnd.raw  = {{(DATA_W-RAW_W){1'b0}}, raw_r};
    opnd.fine = fine_r;
    opnd.imm  = uop.imm;
    a_val     = pick(uop.a, opnd, cal);
    b_val     = pick(uop.b, opnd, cal);
  end

  bptc_alu u_alu (
    .op (uop.op),
    .a  (a_val),
    .b  (b_val),
    .y  (alu_y)
  );

  // doubled dividend when it fits, else the quotient gets doubled afterwards
  assign div_dividend = a_val[DATA_W-1] ? a_val : {a_val[DATA_W-2:0], 1'b0};

  bptc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (b_val),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    mode_nxt  = mode_r;
    raw_nxt   = raw_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    r2_nxt    = r2_r;
    r3_nxt    = r3_r;
    r4_nxt    = r4_r;
    fine_nxt  = fine_r;
    dflag_nxt = dflag_r;
    finish    = 1'b0;
    div_start = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mode_nxt  = mode;
          raw_nxt   = raw;
          step_nxt  = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        case (uop.op)
          OP_BZ: begin
            if (a_val == '0) begin
              finish = 1'b1;
            end else begin
              step_nxt = step_r + STEP_W'(1);
            end
          end
          OP_DIV: begin
            div_start = 1'b1;
            dflag_nxt = a_val[DATA_W-1];
            state_nxt = ST_DIV;
          end
          default: begin
            if (uop.last) begin
              finish = 1'b1;
            end else begin
              step_nxt = step_r + STEP_W'(1);
              case (uop.dst)
                DST_R0:   r0_nxt   = alu_y;
                DST_R1:   r1_nxt   = alu_y;
                DST_R2:   r2_nxt   = alu_y;
                DST_R3:   r3_nxt   = alu_y;
                DST_R4:   r4_nxt   = alu_y;
                DST_FINE: fine_nxt = alu_y;
                default:  r0_nxt   = r0_r;
              endcase
            end
          end
        endcase
        if (finish && res_ready) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          r0_nxt    = dflag_r ? {div_quo[DATA_W-2:0], 1'b0} : div_quo;
          step_nxt  = step_r + STEP_W'(1);
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    raw_r   <= raw_nxt;
    r0_r    <= r0_nxt;
    r1_r    <= r1_nxt;
    r2_r    <= r2_nxt;
    r3_r    <= r3_nxt;
    r4_r    <= r4_nxt;
    dflag_r <= dflag_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      fine_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      fine_r  <= fine_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_kind  = mode_r;
  assign res_value = (uop.op == OP_BZ) ? b_val : alu_y;
endmodule

// ----- rtl/core/baro_temp_pressure_compensation_top.sv -----
// Top level of the barometric temperature and pressure compensation block.
// Depends on bptc_pkg, bptc_in_if, bptc_out_if and bptc_seq.

// Compensates 20-bit raw barometric readings with the 32-bit integer formula. A beat with
// mode 0 is a temperature sample: it updates the stored fine temperature and returns the
// temperature in 0.01 degC. A beat with mode 1 is a pressure sample: it uses the last fine
// temperature (zero after reset) and returns pressure in Pa. Every input beat gives exactly
// one result beat. One item is worked at a time by a micro-program on a single shared
// add/multiply/shift unit, one operation per cycle except while the bit-serial divider
// runs or a finished item is held. A temperature item runs 15 operations, a pressure item
// 40, or it ends with the undivided pressure term when the divisor is zero. The result
// beat becomes valid in the cycle in which the block is ready for the next item. The
// result register frees the sequencer, so the next item can be accepted while a result
// waits to be taken; while that register is still full, a finished item holds the
// sequencer on its last operation. Calibration registers are written through the cfg
// port; the user must do so only while the block is idle, which it does not enforce.
module baro_temp_pressure_compensation_top (
  input  logic                           clk,
  input  logic                           rst_n,
  bptc_in_if.sink                        in_chan,
  bptc_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [bptc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bptc_pkg::DATA_W-1:0]    cfg_data
);
  import bptc_pkg::*;

  logic [COEF_W-1:0] t1_r, t2_r, t3_r, p9_r;
  logic [DATA_W-1:0] p12_r, p34_r, p56_r, p78_r;
  cal_t              cal;

  logic              busy;
  logic              res_valid;
  logic              res_kind;
  logic [DATA_W-1:0] res_value;
  logic              res_ready;

  logic              out_valid_r, out_valid_nxt;
  logic              kind_r;
  logic [DATA_W-1:0] temp_r;
  logic [DATA_W-1:0] pres_r;

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r  <= '0;
      t2_r  <= '0;
      t3_r  <= '0;
      p12_r <= '0;
      p34_r <= '0;
      p56_r <= '0;
      p78_r <= '0;
      p9_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP_CAL_ONE:         t1_r  <= cfg_data[COEF_W-1:0];
        CFG_TEMP_CAL_TWO:         t2_r  <= cfg_data[COEF_W-1:0];
        CFG_TEMP_CAL_THREE:       t3_r  <= cfg_data[COEF_W-1:0];
        CFG_PRES_CAL_ONE_TWO:     p12_r <= cfg_data;
        CFG_PRES_CAL_THREE_FOUR:  p34_r <= cfg_data;
        CFG_PRES_CAL_FIVE_SIX:    p56_r <= cfg_data;
        CFG_PRES_CAL_SEVEN_EIGHT: p78_r <= cfg_data;
        CFG_PRES_CAL_NINE:        p9_r  <= cfg_data[COEF_W-1:0];
        default:                  t1_r  <= t1_r;
      endcase
    end
  end

  // coefficient unpacking
  always_comb begin
    cal.t1 = t1_r;
    cal.t2 = t2_r;
    cal.t3 = t3_r;
    cal.p1 = p12_r[COEF_W-1:0];
    cal.p2 = p12_r[DATA_W-1:COEF_W];
    cal.p3 = p34_r[COEF_W-1:0];
    cal.p4 = p34_r[DATA_W-1:COEF_W];
    cal.p5 = p56_r[COEF_W-1:0];
    cal.p6 = p56_r[DATA_W-1:COEF_W];
    cal.p7 = p78_r[COEF_W-1:0];
    cal.p8 = p78_r[DATA_W-1:COEF_W];
    cal.p9 = p9_r;
  end

  assign in_chan.ready = !busy;

  bptc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_chan.valid && !busy),
    .mode      (in_chan.mode),
    .raw       (in_chan.raw_sample),
    .cal       (cal),
    .res_ready (res_ready),
    .busy      (busy),
    .res_valid (res_valid),
    .res_kind  (res_kind),
    .res_value (res_value)
  );

  // result register
  assign res_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      kind_r <= res_kind;
      temp_r <= res_kind ? '0 : res_value;
      pres_r <= res_kind ? res_value : '0;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.result_kind       = kind_r;
  assign out_chan.temperature_centi = $signed(temp_r);
  assign out_chan.pressure_pa       = pres_r;
endmodule

// ----- rtl/core/bptc_chk.sv -----
// Port-level checker for the compensation block and its bind to the top level.
// Depends on bptc_pkg and baro_temp_pressure_compensation_top.
module bptc_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        result_kind,
  input logic [bptc_pkg::DATA_W-1:0] temperature_centi,
  input logic [bptc_pkg::DATA_W-1:0] pressure_pa
);
  import bptc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
      $stable(temperature_centi) && $stable(pressure_pa))
    else $error("result beat changed while stalled");

  // the block works one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // no result can appear the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early after accept");

  // the field that does not belong to the result kind is zero
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (result_kind == 1'b0 && pressure_pa == '0) ||
      (result_kind == 1'b1 && temperature_centi == '0))
    else $error("unused result field not zero");
endmodule

bind baro_temp_pressure_compensation_top bptc_chk u_bptc_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .result_kind       (out_chan.result_kind),
  .temperature_centi (out_chan.temperature_centi),
  .pressure_pa       (out_chan.pressure_pa)
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for baro_temp_pressure_compensation_top: drives raw sample beats,
// predicts every result with an integer compensation model and checks each result beat.
// Depends on bptc_pkg, bptc_in_if, bptc_out_if and the compensation block RTL.
module tb;
  import bptc_pkg::*;

  localparam logic MODE_TEMP = 1'b0;
  localparam logic MODE_PRES = 1'b1;
  localparam int   NUM_CAL   = 8;

  typedef struct {
    logic                     kind;
    logic signed [DATA_W-1:0] temp_centi;
    logic [DATA_W-1:0]        pres_pa;
  } comp_result_t;

  typedef logic [DATA_W-1:0] cal_set_t [NUM_CAL];

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  bptc_in_if  in_bus ();
  bptc_out_if out_bus ();

  baro_temp_pressure_compensation_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus),
    .out_chan  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model state: calibration words as written and the stored fine temperature
  cal_set_t cal_word;
  cal_set_t staged_cal;
  int fine_temp;

  comp_result_t pending_results [$];
  int error_count;
  int temp_checked;
  int pres_checked;
  int cal_sets_loaded;
  int zero_div_count;
  int idle_max;
  int stall_max;

  // clock, period 10
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // sign-extend one 16-bit coefficient
  function automatic int cal_signed(input logic [COEF_W-1:0] h);
    shortint s;
    s = h;
    return s;
  endfunction

  // fine temperature update and centi-degree result
  function automatic int compensate_temperature(input int ut);
    int t1, t2, t3, a, b, d;
    t1 = int'(cal_word[CFG_TEMP_CAL_ONE][15:0]);
    t2 = cal_signed(cal_word[CFG_TEMP_CAL_TWO][15:0]);
    t3 = cal_signed(cal_word[CFG_TEMP_CAL_THREE][15:0]);
    a = ((ut / 8) - t1 * 2) * t2 / 2048;
    d = ut / 16 - t1;
    b = ((d * d) / 4096 * t3) / 16384;
    fine_temp = a + b;
    return (fine_temp * 5 + 128) / 256;
  endfunction

  // pressure in Pa from the stored fine temperature, 32-bit wrapping throughout
  function automatic logic [DATA_W-1:0] compensate_pressure(input logic [RAW_W-1:0] up);
    int p1, p2, p3, p4, p5, p6, p7, p8, p9;
    int a, b, q, qq, d, corr;
    int unsigned p, e, dv;
    p1 = int'(cal_word[CFG_PRES_CAL_ONE_TWO][15:0]);
    p2 = cal_signed(cal_word[CFG_PRES_CAL_ONE_TWO][31:16]);
    p3 = cal_signed(cal_word[CFG_PRES_CAL_THREE_FOUR][15:0]);
    p4 = cal_signed(cal_word[CFG_PRES_CAL_THREE_FOUR][31:16]);
    p5 = cal_signed(cal_word[CFG_PRES_CAL_FIVE_SIX][15:0]);
    p6 = cal_signed(cal_word[CFG_PRES_CAL_FIVE_SIX][31:16]);
    p7 = cal_signed(cal_word[CFG_PRES_CAL_SEVEN_EIGHT][15:0]);
    p8 = cal_signed(cal_word[CFG_PRES_CAL_SEVEN_EIGHT][31:16]);
    p9 = cal_signed(cal_word[CFG_PRES_CAL_NINE][15:0]);
    a = fine_temp / 2 - 64000;
    q = a / 4;
    qq = q * q;
    b = (qq / 2048) * p6;
    b = b + a * p5 * 2;
    b = b / 4 + p4 * 65536;
    a = ((p3 * (qq / 8192)) / 8 + (p2 * a) / 2) / 262144;
    a = ((32768 + a) * p1) / 32768;
    d = 1048576 - int'({12'd0, up});
    p = (d - b / 4096) * 3125;
    // zero divisor: the undivided term is the result
    if (a == 0) begin
      zero_div_count++;
      return p;
    end
    dv = a;
    if (p < 32'h8000_0000) p = (p << 1) / dv;
    else p = (p / dv) * 2;
    e = (p / 8) * (p / 8);
    a = (p9 * int'(e / 8192)) / 4096;
    b = (int'(p / 4) * p8) / 8192;
    corr = (a + b + p7) / 16;
    p = p + corr;
    return p;
  endfunction

  // send one sample beat after a random gap, predict its result on acceptance
  task automatic send_sample(input logic m, input logic [RAW_W-1:0] raw);
    int gap;
    comp_result_t r;
    gap = $urandom_range(0, idle_max);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.mode       <= m;
    in_bus.raw_sample <= raw;
    do @(posedge clk); while (!in_bus.ready);
    r.kind = m;
    if (m == MODE_TEMP) begin
      r.temp_centi = compensate_temperature(int'({12'd0, raw}));
      r.pres_pa    = '0;
    end else begin
      r.temp_centi = '0;
      r.pres_pa    = compensate_pressure(raw);
    end
    pending_results.push_back(r);
  endtask

  // stop sending and wait until every result beat has been taken
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // write the staged calibration set, one register per cycle
  task automatic load_calibration();
    for (int i = 0; i < NUM_CAL; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= staged_cal[i];
      @(posedge clk);
      cal_word[i] = staged_cal[i];
    end
    cfg_we <= 1'b0;
    cal_sets_loaded++;
  endtask

  // datasheet-like calibration set
  task automatic stage_typical();
    staged_cal[CFG_TEMP_CAL_ONE]         = 32'h0000_6B70;
    staged_cal[CFG_TEMP_CAL_TWO]         = 32'h0000_6743;
    staged_cal[CFG_TEMP_CAL_THREE]       = 32'h0000_FC18;
    staged_cal[CFG_PRES_CAL_ONE_TWO]     = 32'hD643_8E7D;
    staged_cal[CFG_PRES_CAL_THREE_FOUR]  = 32'h0B27_0BD0;
    staged_cal[CFG_PRES_CAL_FIVE_SIX]    = 32'hFFF9_008C;
    staged_cal[CFG_PRES_CAL_SEVEN_EIGHT] = 32'hC6F8_3C8C;
    staged_cal[CFG_PRES_CAL_NINE]        = 32'h0000_1770;
  endtask

  // small random offset on a coefficient
  function automatic logic [15:0] nudge(input logic [15:0] v);
    return v + 16'($urandom_range(0, 2000)) - 16'd1000;
  endfunction

  // draw a calibration set for one phase of random traffic
  task automatic stage_random_cal();
    int pick;
    pick = $urandom_range(0, 5);
    stage_typical();
    for (int i = 0; i < NUM_CAL; i++) begin
      case (pick)
        0, 1, 2: staged_cal[i] = {nudge(staged_cal[i][31:16]), nudge(staged_cal[i][15:0])};
        3:       staged_cal[i] = $urandom;
        4:       staged_cal[i] = staged_cal[i];
        default: begin
          case ($urandom_range(0, 2))
            0:       staged_cal[i] = '0;
            1:       staged_cal[i] = '1;
            default: staged_cal[i] = 32'h8000_8000;
          endcase
        end
      endcase
    end
    // p1 of zero or one makes the pressure divisor zero or tiny
    if (pick == 4) staged_cal[CFG_PRES_CAL_ONE_TWO][15:0] = 16'($urandom_range(0, 1));
    // upper half of the 16-bit registers is ignored by the block
    if ($urandom_range(0, 1) == 1) begin
      staged_cal[CFG_TEMP_CAL_ONE][31:16]   = 16'($urandom);
      staged_cal[CFG_TEMP_CAL_TWO][31:16]   = 16'($urandom);
      staged_cal[CFG_TEMP_CAL_THREE][31:16] = 16'($urandom);
      staged_cal[CFG_PRES_CAL_NINE][31:16]  = 16'($urandom);
    end
  endtask

  // raw reading: mostly in the sensor's working range, sometimes anywhere or at the rails
  function automatic logic [RAW_W-1:0] pick_raw(input logic m);
    case ($urandom_range(0, 5))
      0:       return 20'($urandom_range(0, 20'hFFFFF));
      1:       return ($urandom_range(0, 1) == 1) ? 20'hFFFFF : 20'h00000;
      default: return (m == MODE_TEMP) ? 20'($urandom_range(400000, 600000))
                                       : 20'($urandom_range(200000, 500000));
    endcase
  endfunction

  // zero calibration after reset, pressure before any temperature
  task automatic test_after_reset();
    send_sample(MODE_PRES, 20'h00000);
    send_sample(MODE_PRES, 20'hFFFFF);
    send_sample(MODE_TEMP, 20'h80000);
    drain_results();
  endtask

  // typical calibration with raw extremes on both modes
  task automatic test_typical_cal();
    stage_typical();
    load_calibration();
    send_sample(MODE_TEMP, 20'd519888);
    send_sample(MODE_PRES, 20'd415148);
    send_sample(MODE_TEMP, 20'h00000);
    send_sample(MODE_PRES, 20'h00000);
    send_sample(MODE_TEMP, 20'hFFFFF);
    send_sample(MODE_PRES, 20'hFFFFF);
    drain_results();
  endtask

  // all-ones and most-negative coefficients, intermediates wrap
  task automatic test_extreme_cal();
    for (int i = 0; i < NUM_CAL; i++) staged_cal[i] = '1;
    load_calibration();
    send_sample(MODE_TEMP, 20'hFFFFF);
    send_sample(MODE_PRES, 20'hFFFFF);
    send_sample(MODE_TEMP, 20'h00000);
    send_sample(MODE_PRES, 20'h00000);
    drain_results();
    for (int i = 0; i < NUM_CAL; i++) staged_cal[i] = 32'h8000_8000;
    load_calibration();
    send_sample(MODE_TEMP, 20'hFFFFF);
    send_sample(MODE_PRES, 20'h12345);
    send_sample(MODE_TEMP, 20'h00000);
    send_sample(MODE_PRES, 20'hFFFFF);
    drain_results();
  endtask

  // p1 of zero: pressure comes back undivided and uncorrected
  task automatic test_zero_divisor();
    stage_typical();
    staged_cal[CFG_PRES_CAL_ONE_TWO][15:0] = 16'h0000;
    load_calibration();
    send_sample(MODE_TEMP, 20'd519888);
    send_sample(MODE_PRES, 20'd415148);
    send_sample(MODE_PRES, 20'hFFFFF);
    drain_results();
  endtask

  // phases of temperature-then-pressure sequences with some stray beats,
  // fresh calibration and idle pattern per phase
  task automatic test_random_traffic(input int total);
    int sent;
    int phase_len;
    int in_phase;
    int n_pres;
    logic m;
    sent = 0;
    while (sent < total) begin
      drain_results();
      stage_random_cal();
      load_calibration();
      idle_max  = ($urandom_range(0, 2) == 0) ? 0 : 16;
      stall_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
      phase_len = $urandom_range(60, 140);
      if (phase_len > total - sent) phase_len = total - sent;
      in_phase  = 0;
      while (in_phase < phase_len) begin
        if ($urandom_range(0, 9) < 8) begin
          send_sample(MODE_TEMP, pick_raw(MODE_TEMP));
          n_pres = $urandom_range(1, 3);
          repeat (n_pres) send_sample(MODE_PRES, pick_raw(MODE_PRES));
          in_phase += 1 + n_pres;
        end else begin
          m = 1'($urandom_range(0, 1));
          send_sample(m, 20'($urandom_range(0, 20'hFFFFF)));
          in_phase++;
        end
      end
      sent += in_phase;
    end
  endtask

  // result beat sink: random stalls, compare with the oldest prediction
  initial begin : result_sink
    int stall;
    comp_result_t want;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction pending: kind %0b", out_bus.result_kind);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_bus.result_kind !== want.kind) begin
          $error("result_kind: expected %0b, got %0b", want.kind, out_bus.result_kind);
          error_count++;
        end
        if (out_bus.temperature_centi !== want.temp_centi) begin
          $error("temperature_centi: expected %0d, got %0d",
                 want.temp_centi, out_bus.temperature_centi);
          error_count++;
        end
        if (out_bus.pressure_pa !== want.pres_pa) begin
          $error("pressure_pa: expected %0d, got %0d", want.pres_pa, out_bus.pressure_pa);
          error_count++;
        end
        if (want.kind == MODE_TEMP) temp_checked++;
        else pres_checked++;
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // reset, directed tests, random traffic, final drain
  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.mode       <= MODE_TEMP;
    in_bus.raw_sample <= '0;
    for (int i = 0; i < NUM_CAL; i++) cal_word[i] = '0;
    fine_temp       = 0;
    error_count     = 0;
    temp_checked    = 0;
    pres_checked    = 0;
    cal_sets_loaded = 0;
    zero_div_count  = 0;
    idle_max        = 16;
    stall_max       = 16;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_typical_cal();
    test_extreme_cal();
    test_zero_divisor();
    test_random_traffic(1530);

    drain_results();
    repeat (100) @(posedge clk);
    $display("checked %0d temperature and %0d pressure results", temp_checked, pres_checked);
    $display("over %0d calibration sets, %0d pressure results with a zero divisor",
             cal_sets_loaded, zero_div_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d predicted results never arrived", pending_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
